// File: rtl/lsa_pkg.sv
// ----------------------------------------------------------------------------
// lsa_pkg: shared types and constants of the lidar sector avoidance unit
// Holds the register map, the configuration bundle, the drive mode codes and
// the item formats that pass between the front, the queues and the back.
// ----------------------------------------------------------------------------
package lsa_pkg;

  // Default angle resolution and queue depths.
  localparam int ANGLE_BITS_DEF   = 16;
  localparam int TICK_Q_DEPTH_DEF = 2;
  localparam int OUT_Q_DEPTH_DEF  = 2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_FRONT_LIMIT = 3'd0;
  localparam logic [2:0] CFG_SIDE_LIMIT  = 3'd1;
  localparam logic [2:0] CFG_HALF_ARC    = 3'd2;
  localparam logic [2:0] CFG_LEFT_ARC    = 3'd3;
  localparam logic [2:0] CFG_RIGHT_ARC   = 3'd4;
  localparam logic [2:0] CFG_TURN_TICKS  = 3'd5;
  localparam logic [2:0] CFG_CRUISE      = 3'd6;
  localparam logic [2:0] CFG_TURN_RATE   = 3'd7;

  // Request types.
  localparam logic REQ_BEAM = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Obstacle flag bit positions.
  localparam int FLAG_AHEAD = 0;
  localparam int FLAG_LEFT  = 1;
  localparam int FLAG_RIGHT = 2;

  // Drive modes of the avoidance machine.
  typedef enum logic [2:0] {
    MODE_STOPPED = 3'd0,
    MODE_FORWARD = 3'd1,
    MODE_RIGHT   = 3'd2,
    MODE_LEFT    = 3'd3,
    MODE_AROUND  = 3'd4
  } mode_t;

  // Configuration registers as one bundle.
  typedef struct packed {
    logic [15:0] front_limit_mm;
    logic [15:0] side_limit_mm;
    logic [14:0] half_forward_arc;
    logic [14:0] left_arc_width;
    logic [14:0] right_arc_width;
    logic [7:0]  short_turn_ticks;
    logic [15:0] cruise_speed;
    logic [14:0] turn_rate;
  } cfg_t;

  // A control tick with the obstacle flags committed at its arrival.
  typedef struct packed {
    logic [2:0] flags;
    logic       coin;
  } tick_t;

  // One result item.
  typedef struct packed {
    logic [2:0]         drive_state;
    logic [15:0]        linear_cmd;
    logic signed [15:0] angular_cmd;
  } result_t;

  // Flag status of the front, seen by the checks at the top level.
  typedef struct packed {
    logic [2:0] pending;
    logic [2:0] committed;
  } front_stat_t;

endpackage

// File: rtl/lsa_fifo.sv
// ----------------------------------------------------------------------------
// lsa_fifo: small first-in first-out queue
// A register file with wrapping pointers and an occupancy count. The head
// entry is presented while the queue is not empty.
// ----------------------------------------------------------------------------
module lsa_fifo #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == (AW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Pointer and count update; pointers wrap at the depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: rtl/lsa_front.sv
// ----------------------------------------------------------------------------
// lsa_front: beam classifier and tick dispatcher
// Sorts each valid beam into the ahead, left and right sectors, keeps the
// pending flags of the scan in progress and commits them on the last beam.
// A control tick is passed on with the committed flags and its coin bit.
// ----------------------------------------------------------------------------
module lsa_front #(
  parameter int ANGLE_BITS = lsa_pkg::ANGLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lsa_pkg::cfg_t         cfg,
  input  logic                  accept,
  input  logic                  req_type,
  input  logic [ANGLE_BITS-1:0] beam_angle,
  input  logic [15:0]           beam_range_mm,
  input  logic                  beam_valid,
  input  logic                  last_beam,
  input  logic                  coin,
  output logic                  tick_push,
  output lsa_pkg::tick_t        tick_item,
  output lsa_pkg::front_stat_t  stat
);

  import lsa_pkg::*;

  // Wide enough for the signed angle and the sum of two arc registers.
  localparam int DW = (ANGLE_BITS >= 16) ? ANGLE_BITS + 2 : 18;

  localparam logic [ANGLE_BITS-1:0] HALF_CIRCLE = {1'b1, {(ANGLE_BITS-1){1'b0}}};

  logic [2:0]           pending_r, pending_nxt;
  logic [2:0]           committed_r, committed_nxt;
  logic signed [DW-1:0] delta, half_s, left_edge, right_edge;
  logic [2:0]           hit;

  // Signed beam angle; the half circle is taken as positive.
  always_comb begin
    if (beam_angle == HALF_CIRCLE) begin
      delta = signed'(DW'(beam_angle));
    end else begin
      delta = DW'(signed'(beam_angle));
    end
  end

  // Sector edges from the arc registers.
  assign half_s     = signed'(DW'(cfg.half_forward_arc));
  assign left_edge  = half_s + signed'(DW'(cfg.left_arc_width));
  assign right_edge = half_s + signed'(DW'(cfg.right_arc_width));

  // Sector hits; one beam may fall in more than one sector.
  always_comb begin
    hit = '0;
    hit[FLAG_AHEAD] = (delta <= half_s) && (delta >= -half_s) &&
                      (beam_range_mm < cfg.front_limit_mm);
    hit[FLAG_LEFT]  = (delta >= half_s) && (delta <= left_edge) &&
                      (beam_range_mm < cfg.side_limit_mm);
    hit[FLAG_RIGHT] = (delta <= -half_s) && (delta >= -right_edge) &&
                      (beam_range_mm < cfg.side_limit_mm);
  end

  // Flag update for an accepted beam; the last beam commits the scan.
  always_comb begin
    pending_nxt   = pending_r;
    committed_nxt = committed_r;
    if (accept && (req_type == REQ_BEAM)) begin
      if (beam_valid) begin
        pending_nxt = pending_r | hit;
      end
      if (last_beam) begin
        committed_nxt = pending_nxt;
        pending_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r   <= '0;
      committed_r <= '0;
    end else begin
      pending_r   <= pending_nxt;
      committed_r <= committed_nxt;
    end
  end

  // Ticks go to the back with the flags of the last finished scan.
  assign tick_push       = accept && (req_type == REQ_TICK);
  assign tick_item.flags = committed_r;
  assign tick_item.coin  = coin;

  assign stat.pending   = pending_r;
  assign stat.committed = committed_r;

endmodule

// File: rtl/lsa_back.sv
// ----------------------------------------------------------------------------
// lsa_back: avoidance state machine
// Runs one step of the Stopped, Forward, TurnRight, TurnLeft and TurnAround
// machine for each tick taken from the tick queue and pushes the drive
// state with its speed commands into the result queue.
// ----------------------------------------------------------------------------
module lsa_back (
  input  logic             clk,
  input  logic             rst_n,
  input  lsa_pkg::cfg_t    cfg,
  input  logic             tick_empty,
  input  lsa_pkg::tick_t   tick_item,
  output logic             tick_pop,
  input  logic             res_full,
  output logic             res_push,
  output lsa_pkg::result_t res_item
);

  import lsa_pkg::*;

  mode_t       mode_r, mode_nxt;
  logic [10:0] turn_rem_r, turn_rem_nxt;
  logic [10:0] ticks_side, ticks_wall, ticks_corner;
  logic        step;

  // Turn lengths: one, two and six times the short turn.
  assign ticks_side   = {3'b000, cfg.short_turn_ticks};
  assign ticks_wall   = {2'b00, cfg.short_turn_ticks, 1'b0};
  assign ticks_corner = {1'b0, cfg.short_turn_ticks, 2'b00} + ticks_wall;

  assign step     = !tick_empty && !res_full;
  assign tick_pop = step;
  assign res_push = step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_STOPPED;
      turn_rem_r <= '0;
    end else begin
      mode_r     <= mode_nxt;
      turn_rem_r <= turn_rem_nxt;
    end
  end

  // Next mode for a tick, and the commands of the mode it leaves us in.
  always_comb begin
    mode_nxt     = mode_r;
    turn_rem_nxt = turn_rem_r;
    if (step) begin
      case (mode_r)
        MODE_FORWARD: begin
          if (tick_item.flags != '0) begin
            mode_nxt = MODE_STOPPED;
          end
        end
        MODE_STOPPED: begin
          if (tick_item.flags[FLAG_AHEAD]) begin
            mode_nxt     = tick_item.coin ? MODE_RIGHT : MODE_LEFT;
            turn_rem_nxt = ticks_wall;
          end else if (tick_item.flags[FLAG_LEFT] && tick_item.flags[FLAG_RIGHT]) begin
            mode_nxt     = MODE_AROUND;
            turn_rem_nxt = ticks_corner;
          end else if (tick_item.flags[FLAG_LEFT]) begin
            mode_nxt     = MODE_RIGHT;
            turn_rem_nxt = ticks_side;
          end else if (tick_item.flags[FLAG_RIGHT]) begin
            mode_nxt     = MODE_LEFT;
            turn_rem_nxt = ticks_side;
          end else begin
            mode_nxt = MODE_FORWARD;
          end
        end
        default: begin
          // Any turn counts down and stops when the count runs out.
          if (turn_rem_r != '0) begin
            turn_rem_nxt = turn_rem_r - 1'b1;
          end
          if (turn_rem_nxt == '0) begin
            mode_nxt = MODE_STOPPED;
          end
        end
      endcase
    end

    res_item.drive_state = mode_nxt;
    res_item.linear_cmd  = '0;
    res_item.angular_cmd = '0;
    case (mode_nxt)
      MODE_FORWARD: res_item.linear_cmd  = cfg.cruise_speed;
      MODE_RIGHT:   res_item.angular_cmd = -signed'({1'b0, cfg.turn_rate});
      MODE_LEFT:    res_item.angular_cmd = signed'({1'b0, cfg.turn_rate});
      MODE_AROUND:  res_item.angular_cmd = signed'({1'b0, cfg.turn_rate});
      default:      res_item.linear_cmd  = '0;
    endcase
  end

endmodule

// File: rtl/lidar_sector_avoidance_fsm_unit.sv
// ----------------------------------------------------------------------------
// lidar_sector_avoidance_fsm_unit: lidar sector detector with avoidance FSM
// Beams set sector obstacle flags that the last beam of a scan commits;
// control ticks step the drive machine and return state and speed commands.
//
//   Channel | Ports                                     | Accepted when
//   --------+-------------------------------------------+----------------------
//   input   | in_push, in_full, in_* fields             | in_push && !in_full
//   result  | out_empty, out_pop, out_* fields          | out_pop && !out_empty
//   config  | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid && cfg_ready
//
// One item per cycle while in_full is low. A beam updates the sector flags at
// the edge that takes it. A tick waits in a two-entry tick queue, is stepped by
// the state machine from there once the result queue is not full and lands in
// a two-entry result queue. in_full rises only when the tick queue fills, which
// takes a full result queue.
// Reset restores the register defaults and empties both queues; cfg_ready is 1.
// ----------------------------------------------------------------------------
module lidar_sector_avoidance_fsm_unit #(
  parameter int ANGLE_BITS   = lsa_pkg::ANGLE_BITS_DEF,
  parameter int TICK_Q_DEPTH = lsa_pkg::TICK_Q_DEPTH_DEF,
  parameter int OUT_Q_DEPTH  = lsa_pkg::OUT_Q_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic                  in_req_type,
  input  logic [ANGLE_BITS-1:0] in_beam_angle,
  input  logic [15:0]           in_beam_range_mm,
  input  logic                  in_beam_valid,
  input  logic                  in_last_beam,
  input  logic                  in_coin,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [2:0]            out_drive_state,
  output logic [15:0]           out_linear_cmd,
  output logic signed [15:0]    out_angular_cmd,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [15:0]           cfg_data
);

  import lsa_pkg::*;

  cfg_t        cfg_r;
  logic        in_accept;
  logic        tick_push, tick_pop, tick_empty, res_push, res_full;
  tick_t       tick_in, tick_out;
  result_t     res_in, res_out;
  front_stat_t fstat;

  assign cfg_ready = 1'b1;
  assign in_accept = in_push && !in_full;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.front_limit_mm   <= 16'd418;
      cfg_r.side_limit_mm    <= 16'd462;
      cfg_r.half_forward_arc <= 15'd3641;
      cfg_r.left_arc_width   <= 15'd4551;
      cfg_r.right_arc_width  <= 15'd4551;
      cfg_r.short_turn_ticks <= 8'd9;
      cfg_r.cruise_speed     <= 16'd300;
      cfg_r.turn_rate        <= 15'd600;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FRONT_LIMIT: cfg_r.front_limit_mm   <= cfg_data;
        CFG_SIDE_LIMIT:  cfg_r.side_limit_mm    <= cfg_data;
        CFG_HALF_ARC:    cfg_r.half_forward_arc <= cfg_data[14:0];
        CFG_LEFT_ARC:    cfg_r.left_arc_width   <= cfg_data[14:0];
        CFG_RIGHT_ARC:   cfg_r.right_arc_width  <= cfg_data[14:0];
        CFG_TURN_TICKS:  cfg_r.short_turn_ticks <= cfg_data[7:0];
        CFG_CRUISE:      cfg_r.cruise_speed     <= cfg_data;
        CFG_TURN_RATE:   cfg_r.turn_rate        <= cfg_data[14:0];
        default:         cfg_r.turn_rate        <= cfg_r.turn_rate;
      endcase
    end
  end

  // Front: beam classification and tick dispatch.
  lsa_front #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .accept       (in_accept),
    .req_type     (in_req_type),
    .beam_angle   (in_beam_angle),
    .beam_range_mm(in_beam_range_mm),
    .beam_valid   (in_beam_valid),
    .last_beam    (in_last_beam),
    .coin         (in_coin),
    .tick_push    (tick_push),
    .tick_item    (tick_in),
    .stat         (fstat)
  );

  // Tick queue between front and back.
  lsa_fifo #(
    .WIDTH($bits(tick_t)),
    .DEPTH(TICK_Q_DEPTH)
  ) u_tick_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (tick_push),
    .wdata(tick_in),
    .pop  (tick_pop),
    .rdata(tick_out),
    .full (in_full),
    .empty(tick_empty)
  );

  // Back: the drive state machine.
  lsa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .tick_empty(tick_empty),
    .tick_item (tick_out),
    .tick_pop  (tick_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_item  (res_in)
  );

  // Result queue toward the consumer.
  lsa_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(OUT_Q_DEPTH)
  ) u_out_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_push),
    .wdata(res_in),
    .pop  (out_pop),
    .rdata(res_out),
    .full (res_full),
    .empty(out_empty)
  );

  assign out_drive_state = res_out.drive_state;
  assign out_linear_cmd  = res_out.linear_cmd;
  assign out_angular_cmd = res_out.angular_cmd;

`ifndef SYNTH
  // An accepted tick is waiting in the tick queue at the next edge.
  a_tick_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_req_type == REQ_TICK)) |=> !tick_empty)
    else $error("accepted tick missing from the tick queue");

  // A last beam always leaves the pending flags clear.
  a_commit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_req_type == REQ_BEAM) && in_last_beam) |=> (fstat.pending == '0))
    else $error("pending flags not cleared by the last beam");

  // Within a scan the pending flags only gain bits.
  a_pending_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_req_type == REQ_BEAM) && !in_last_beam) |=>
    ((fstat.pending & $past(fstat.pending)) == $past(fstat.pending)))
    else $error("pending flags lost bits inside a scan");

  // A tick leaves both flag sets untouched.
  a_tick_keeps_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_req_type == REQ_TICK)) |=> $stable(fstat))
    else $error("flags changed on a tick");
`endif

endmodule
